### rtl/core/sha1_pkg.sv
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared constants and control types for the SHA-1 byte stream hasher.
// ----------------------------------------------------------------------------
package sha1_pkg;

  localparam int ROUNDS = 80;
  localparam int BLOCK_WORDS = 16;
  localparam int CHAIN_WORDS = 5;

  // initial chaining values
  localparam logic [31:0] H_INIT [CHAIN_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  // round constants, one per group of 20 rounds
  localparam logic [31:0] K_0 = 32'h5A827999;
  localparam logic [31:0] K_1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // first byte position that no longer leaves room for the length field
  localparam logic [5:0] LEN_POS = 6'd56;

  // commands to the round unit
  typedef struct packed {
    logic load;   // working vars <= chain
    logic step;   // run one round
    logic fold;   // chain <= chain + working vars
    logic init;   // chain <= initial values
  } rnd_ctl_t;

  // commands to the block buffer / schedule
  typedef struct packed {
    logic       byte_we;  // write one message byte at pos
    logic       pad;      // 0x80 at pos, zeros after it
    logic       len_we;   // write bit length into words 14 and 15
    logic       clear;    // zero the whole block
    logic       shift;    // advance the message schedule one round
    logic [5:0] pos;
  } sched_ctl_t;

endpackage

### rtl/core/sha1_byte_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher
// SHA-1 over a byte stream, one byte per input beat, digest per message.
// ----------------------------------------------------------------------------
// Every 64th byte starts a block compression (load, 80 rounds on the one
// shared round unit, fold). An end-of-message beat adds padding and one
// compression when the bytes left in the last block are 55 or fewer, else
// two, before the digest beat appears; when the closing byte itself
// completes a block, the data block and then the padding block are
// compressed. The digest sits in an output register; the next message may
// stream in while it waits, and the block stalls only when a new digest is
// ready before the old one has been taken. in_ready is low during
// compression.
// ----------------------------------------------------------------------------
module sha1_byte_stream_hasher import sha1_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word_0,
  output logic [31:0] digest_word_1,
  output logic [31:0] digest_word_2,
  output logic [31:0] digest_word_3,
  output logic [31:0] digest_word_4
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_RUN   = 3'd2;
  localparam logic [2:0] S_FOLD  = 3'd3;
  localparam logic [2:0] S_PAD   = 3'd4;
  localparam logic [2:0] S_LEN   = 3'd5;

  // which block is being compressed
  localparam logic [1:0] BLK_DATA  = 2'd0;
  localparam logic [1:0] BLK_PAD   = 2'd1;
  localparam logic [1:0] BLK_FINAL = 2'd2;

  logic [2:0]  state, state_next;
  logic [1:0]  blk, blk_next;
  logic        pend_last, pend_last_next;
  logic [60:0] count, count_next;
  logic        out_load;

  rnd_ctl_t    rctl;
  sched_ctl_t  sctl;
  logic [31:0] w_cur;
  logic        last_round;
  logic [31:0] sum [CHAIN_WORDS];
  logic        in_beat;

  assign in_ready = (state == S_IDLE);
  assign in_beat  = in_valid && in_ready;

  sha1_sched u_sched (
    .clk     (clk),
    .ctl     (sctl),
    .wr_byte (data_byte),
    .bit_len ({count, 3'b000}),
    .w_cur   (w_cur)
  );

  sha1_round u_round (
    .clk        (clk),
    .rst        (rst),
    .ctl        (rctl),
    .w_cur      (w_cur),
    .last_round (last_round),
    .sum        (sum)
  );

  // sequencer
  always_comb begin
    state_next     = state;
    blk_next       = blk;
    pend_last_next = pend_last;
    count_next     = count;
    out_load       = 1'b0;
    rctl           = '0;
    sctl           = '0;
    sctl.pos       = count[5:0];
    unique case (state)
      S_IDLE: begin
        if (in_beat) begin
          pend_last_next = end_of_message;
          if (byte_present) begin
            sctl.byte_we = 1'b1;
            count_next   = count + 61'd1;
            if (count[5:0] == 6'h3F) begin
              blk_next   = BLK_DATA;
              state_next = S_START;
            end else if (end_of_message) begin
              state_next = S_PAD;
            end
          end else if (end_of_message) begin
            state_next = S_PAD;
          end
        end
      end
      S_PAD: begin
        sctl.pad = 1'b1;
        if (count[5:0] >= LEN_POS) begin
          blk_next = BLK_PAD;
        end else begin
          sctl.len_we = 1'b1;
          blk_next    = BLK_FINAL;
        end
        state_next = S_START;
      end
      S_LEN: begin
        sctl.clear  = 1'b1;
        sctl.len_we = 1'b1;
        blk_next    = BLK_FINAL;
        state_next  = S_START;
      end
      S_START: begin
        rctl.load  = 1'b1;
        state_next = S_RUN;
      end
      S_RUN: begin
        rctl.step  = 1'b1;
        sctl.shift = 1'b1;
        if (last_round) state_next = S_FOLD;
      end
      S_FOLD: begin
        unique case (blk)
          BLK_DATA: begin
            rctl.fold  = 1'b1;
            state_next = pend_last ? S_PAD : S_IDLE;
          end
          BLK_PAD: begin
            rctl.fold  = 1'b1;
            state_next = S_LEN;
          end
          default: begin
            // final block: wait for room in the output register
            if (!out_valid || out_ready) begin
              out_load   = 1'b1;
              rctl.init  = 1'b1;
              count_next = '0;
              state_next = S_IDLE;
            end
          end
        endcase
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      blk       <= BLK_DATA;
      pend_last <= 1'b0;
      count     <= '0;
    end else begin
      state     <= state_next;
      blk       <= blk_next;
      pend_last <= pend_last_next;
      count     <= count_next;
    end
  end

  // digest output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      digest_word_0 <= sum[0];
      digest_word_1 <= sum[1];
      digest_word_2 <= sum[2];
      digest_word_3 <= sum[3];
      digest_word_4 <= sum[4];
    end
  end

endmodule

### rtl/core/sha1_sched.sv
// ----------------------------------------------------------------------------
// sha1_sched
// 16-word block buffer that doubles as the message schedule window.
// ----------------------------------------------------------------------------
module sha1_sched import sha1_pkg::*; (
  input  logic        clk,
  input  sched_ctl_t  ctl,
  input  logic [7:0]  wr_byte,
  input  logic [63:0] bit_len,
  output logic [31:0] w_cur
);

  logic [31:0] w      [BLOCK_WORDS];
  logic [31:0] w_next [BLOCK_WORDS];
  logic [31:0] w_mix;
  logic [31:0] w_new;

  // next schedule word, w[t+16]
  assign w_mix = w[13] ^ w[8] ^ w[2] ^ w[0];
  assign w_new = {w_mix[30:0], w_mix[31]};
  assign w_cur = w[0];

  always_comb begin
    w_next = w;
    if (ctl.clear) begin
      for (int i = 0; i < BLOCK_WORDS; i++) w_next[i] = '0;
    end
    // byte lanes, big-endian inside each word
    for (int i = 0; i < BLOCK_WORDS; i++) begin
      for (int j = 0; j < 4; j++) begin
        if (ctl.pad && 6'(4 * i + j) == ctl.pos) w_next[i][31 - 8*j -: 8] = PAD_BYTE;
        if (ctl.pad && 6'(4 * i + j) > ctl.pos) w_next[i][31 - 8*j -: 8] = '0;
        if (ctl.byte_we && 6'(4 * i + j) == ctl.pos) w_next[i][31 - 8*j -: 8] = wr_byte;
      end
    end
    if (ctl.len_we) begin
      w_next[BLOCK_WORDS-2] = bit_len[63:32];
      w_next[BLOCK_WORDS-1] = bit_len[31:0];
    end
    if (ctl.shift) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) w_next[i] = w[i+1];
      w_next[BLOCK_WORDS-1] = w_new;
    end
  end

  always_ff @(posedge clk) begin
    w <= w_next;
  end

endmodule

### rtl/core/sha1_round.sv
// ----------------------------------------------------------------------------
// sha1_round
// Chaining words, working variables and the single shared round datapath.
// ----------------------------------------------------------------------------
module sha1_round import sha1_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  rnd_ctl_t    ctl,
  input  logic [31:0] w_cur,
  output logic        last_round,
  output logic [31:0] sum [CHAIN_WORDS]
);

  logic [31:0] h [CHAIN_WORDS];
  logic [31:0] a, b, c, d, e;
  logic [6:0]  rnd;
  logic [31:0] f, k, t;

  assign last_round = (rnd == 7'(ROUNDS - 1));

  // chain plus working vars, used for fold and for the digest
  assign sum[0] = h[0] + a;
  assign sum[1] = h[1] + b;
  assign sum[2] = h[2] + c;
  assign sum[3] = h[3] + d;
  assign sum[4] = h[4] + e;

  // round function and constant by round group
  always_comb begin
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K_0;
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
      k = K_1;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K_2;
    end else begin
      f = b ^ c ^ d;
      k = K_3;
    end
    t = {a[26:0], a[31:27]} + f + e + k + w_cur;
  end

  // chaining words
  always_ff @(posedge clk) begin
    if (rst || ctl.init) begin
      for (int i = 0; i < CHAIN_WORDS; i++) h[i] <= H_INIT[i];
    end else if (ctl.fold) begin
      h <= sum;
    end
  end

  // round counter
  always_ff @(posedge clk) begin
    if (rst || ctl.load) begin
      rnd <= '0;
    end else if (ctl.step) begin
      rnd <= last_round ? '0 : rnd + 7'd1;
    end
  end

  // working variables
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a <= h[0];
      b <= h[1];
      c <= h[2];
      d <= h[3];
      e <= h[4];
    end else if (ctl.step) begin
      a <= t;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end
  end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the SHA-1 byte stream hasher. Messages are streamed in one
// byte per beat, some ending on a data byte and some on an empty end beat,
// with bubble beats mixed in. Each accepted beat is folded into a software
// SHA-1 model. Every digest that model produces is queued and compared word
// by word against the digest beats coming out of the block. Lengths cluster
// around the padding boundaries at 55/56 and 63/64 bytes. Both sides idle
// at random, and the output is held off for a long stretch once.
// ----------------------------------------------------------------------------
module tb;
  import sha1_pkg::*;

  localparam int TOTAL_BEATS = 1650;
  localparam int CALM_TAIL   = 200;   // beats at the end sent without idling
  localparam int LONG_HOLD   = 600;   // cycles the sink stays blocked once
  localparam int WATCHDOG    = 5000;  // cycles with no beat on either side
  localparam int TAIL_CYCLES = 200;   // cycles run on after the last digest is out

  typedef logic [CHAIN_WORDS-1:0][31:0] digest_t;

  logic        clk;
  logic        rst            = 1'b1;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte      = 8'h00;
  logic        byte_present   = 1'b0;
  logic        end_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [31:0] digest_word_0;
  logic [31:0] digest_word_1;
  logic [31:0] digest_word_2;
  logic [31:0] digest_word_3;
  logic [31:0] digest_word_4;

  // run control, written with nonblocking assignments by the stimulus
  logic idle_en      = 1'b1;
  logic hold_request = 1'b0;

  int fails      = 0;
  int beats_sent = 0;

  // software hash state
  logic [31:0] chain_h [CHAIN_WORDS];
  logic [31:0] blk [BLOCK_WORDS];
  logic [60:0] byte_cnt;
  digest_t     pending_digests [$];

  sha1_byte_stream_hasher dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .byte_present   (byte_present),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .digest_word_0  (digest_word_0),
    .digest_word_1  (digest_word_1),
    .digest_word_2  (digest_word_2),
    .digest_word_3  (digest_word_3),
    .digest_word_4  (digest_word_4)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // SHA-1 model
  // --------------------------------------------------------------------------
  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic sha1_compress();
    logic [31:0] w [ROUNDS];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < BLOCK_WORDS; i++) w[i] = blk[i];
    for (int i = BLOCK_WORDS; i < ROUNDS; i++)
      w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3]; e = chain_h[4];
    for (int r = 0; r < ROUNDS; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K_0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K_1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_2;
      end else begin
        f = b ^ c ^ d;
        k = K_3;
      end
      t = rol(a, 5) + f + e + k + w[r];
      e = d;
      d = c;
      c = rol(b, 30);
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endtask

  task automatic put_byte(input int pos, input logic [7:0] v);
    blk[pos / 4][8 * (3 - pos % 4) +: 8] = v;
  endtask

  task automatic hash_reset();
    chain_h  = H_INIT;
    byte_cnt = '0;
    foreach (blk[i]) blk[i] = '0;
  endtask

  // fold one accepted beat into the model; a closing beat queues a digest
  task automatic hash_beat(input logic [7:0] d, input logic p, input logic e);
    int          pos;
    logic [63:0] bits;
    digest_t     dg;
    if (p) begin
      put_byte(int'(byte_cnt[5:0]), d);
      byte_cnt = byte_cnt + 61'd1;
      if (byte_cnt[5:0] == 6'd0) sha1_compress();
    end
    if (e) begin
      pos = int'(byte_cnt[5:0]);
      put_byte(pos, PAD_BYTE);
      for (int i = pos + 1; i < 64; i++) put_byte(i, 8'h00);
      // no room for the length: spill into a second block
      if (pos >= int'(LEN_POS)) begin
        sha1_compress();
        foreach (blk[i]) blk[i] = '0;
      end
      bits    = {byte_cnt, 3'b000};
      blk[14] = bits[63:32];
      blk[15] = bits[31:0];
      sha1_compress();
      for (int i = 0; i < CHAIN_WORDS; i++) dg[i] = chain_h[i];
      pending_digests = {pending_digests, dg};
      chain_h  = H_INIT;
      byte_cnt = '0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Entered and left at a rising edge; valid stays high on return.
  task automatic send_beat(input logic [7:0] d, input logic p, input logic e);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    data_byte      <= d;
    byte_present   <= p;
    end_of_message <= e;
    do @(posedge clk); while (!in_ready);
    hash_beat(d, p, e);
    if (p || e) beats_sent++;
  endtask

  task automatic send_message(input int len, input bit byte_on_end, input bit noise);
    for (int i = 0; i < len; i++) begin
      if (noise && $urandom_range(0, 9) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
      send_beat(8'($urandom), 1'b1, byte_on_end && (i == len - 1));
    end
    if (!byte_on_end || len == 0) send_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  // sender stands still until every queued digest has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_digests.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Output side: random stalls plus one long hold on request
  // --------------------------------------------------------------------------
  int  hold_left  = 0;
  int  stall_left = 0;
  logic hold_seen = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      hold_left  <= 0;
      stall_left <= 0;
      hold_seen  <= 1'b0;
    end else begin
      if (!hold_request) hold_seen <= 1'b0;
      if (hold_request && !hold_seen) begin
        hold_seen <= 1'b1;
        hold_left <= LONG_HOLD;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 12);
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // compare each digest beat against the oldest queued digest
  always @(posedge clk) begin : check_digest
    digest_t want, got;
    if (!rst && out_valid && out_ready) begin
      got[0] = digest_word_0;
      got[1] = digest_word_1;
      got[2] = digest_word_2;
      got[3] = digest_word_3;
      got[4] = digest_word_4;
      if (pending_digests.size() == 0) begin
        $error("digest beat with no message closed: %h", got);
        fails++;
      end else begin
        want = pending_digests.pop_front();
        for (int i = 0; i < CHAIN_WORDS; i++)
          if (got[i] !== want[i]) begin
            $error("digest_word_%0d: expected %h, got %h", i, want[i], got[i]);
            fails++;
          end
      end
    end
  end

  // watchdog on beats in either direction
  int quiet = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet <= 0;
      end else if (quiet >= WATCHDOG) begin
        $display("tb: FAIL");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // empty message, ignored bytes, bubbles, short known messages
  task automatic test_directed();
    send_beat(8'hA5, 1'b0, 1'b1);              // empty message, byte ignored
    send_beat(8'hFF, 1'b0, 1'b0);              // bubble
    send_beat(8'h61, 1'b1, 1'b0);              // "abc"
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b0);              // bubble mid-message
    send_beat(8'h63, 1'b1, 1'b1);
    send_beat(8'h00, 1'b1, 1'b0);              // extremes, closed by empty end
    send_beat(8'hFF, 1'b1, 1'b0);
    send_beat(8'h5A, 1'b0, 1'b1);
    send_beat(8'hFF, 1'b1, 1'b1);              // one-byte message
    send_beat(8'h00, 1'b1, 1'b1);              // one-byte then empty, back to back
    send_beat(8'h00, 1'b0, 1'b1);
  endtask

  // lengths on both sides of the one-block / two-block padding split
  task automatic test_pad_boundaries();
    int lens [] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};
    foreach (lens[i]) send_message(lens[i], 1'(lens[i] % 2), 1'b1);
  endtask

  // block the sink long enough for the input side to stall behind it
  task automatic test_output_backpressure();
    hold_request <= 1'b1;
    for (int i = 0; i < 5; i++) send_message($urandom_range(1, 4), 1'(i % 2), 1'b0);
    hold_request <= 1'b0;
    wait_drained();
  endtask

  task automatic test_random_messages();
    int len;
    bit paused = 1'b0;
    while (beats_sent < TOTAL_BEATS) begin
      case ($urandom_range(0, 9))
        0:       len = 0;
        1, 2:    len = $urandom_range(52, 68);
        3:       len = $urandom_range(116, 132);
        default: len = $urandom_range(1, 40);
      endcase
      send_message(len, 1'($urandom), 1'b1);
      if (!paused && beats_sent > TOTAL_BEATS / 2) begin
        paused = 1'b1;
        wait_drained();
      end
      if (beats_sent >= TOTAL_BEATS - CALM_TAIL) idle_en <= 1'b0;
    end
  endtask

  initial begin
    hash_reset();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_pad_boundaries();
    test_output_backpressure();
    test_random_messages();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
